// File: rtl/nlp_pkg.sv
package nlp_pkg;

   // Accumulator width; the value port stays 64 bits and is zero-extended.
   localparam int VALUE_WIDTH = 64;

   typedef logic [VALUE_WIDTH-1:0] acc_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FLOAT = 2'd1,
      STATUS_BAD   = 2'd2
   } status_type;

   localparam logic [7:0] CHAR_0   = 8'h30;
   localparam logic [7:0] CHAR_9   = 8'h39;
   localparam logic [7:0] CHAR_LA  = 8'h61;
   localparam logic [7:0] CHAR_LF  = 8'h66;
   localparam logic [7:0] CHAR_UA  = 8'h41;
   localparam logic [7:0] CHAR_UF  = 8'h46;
   localparam logic [7:0] CHAR_LX  = 8'h78;
   localparam logic [7:0] CHAR_UX  = 8'h58;
   localparam logic [7:0] CHAR_LO  = 8'h6f;
   localparam logic [7:0] CHAR_UO  = 8'h4f;
   localparam logic [7:0] CHAR_LB  = 8'h62;
   localparam logic [7:0] CHAR_UB  = 8'h42;
   localparam logic [7:0] CHAR_LU  = 8'h75;
   localparam logic [7:0] CHAR_UU  = 8'h55;
   localparam logic [7:0] CHAR_LD  = 8'h64;
   localparam logic [7:0] CHAR_UD  = 8'h44;
   localparam logic [7:0] CHAR_DOT = 8'h2e;

   localparam logic [4:0] NOT_A_DIGIT = 5'd16;

   // Running parse state between characters of one literal.
   typedef struct packed {
      logic [7:0] held;
      logic [1:0] count;
      radix_type  radix;
      acc_type    acc;
      logic       bad;
      logic       dot;
   } parse_state_type;

   // Everything the finishing stage needs once the last character is in.
   typedef struct packed {
      logic [7:0] final_char;
      radix_type  radix;
      acc_type    acc;
      logic       bad;
      logic       dot;
   } pending_type;

   typedef struct packed {
      acc_type acc;
      logic    bad;
   } digit_result_type;

   function automatic logic [4:0] digit_of(input logic [7:0] c);
      logic [4:0] d;
      d = NOT_A_DIGIT;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         d = 5'(c - CHAR_0);
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
         d = 5'(c - CHAR_LA) + 5'd10;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
         d = 5'(c - CHAR_UA) + 5'd10;
      end
      return d;
   endfunction

   function automatic logic [4:0] base_of(input radix_type radix);
      logic [4:0] b;
      unique case (radix)
         RADIX_HEX: b = 5'd16;
         RADIX_OCT: b = 5'd8;
         RADIX_BIN: b = 5'd2;
         default:   b = 5'd10;
      endcase
      return b;
   endfunction

   // One step of acc = acc * base + digit, with the multiply as shifts.
   // An invalid digit leaves the accumulator alone and raises bad.
   function automatic digit_result_type take_digit(input acc_type acc,
                                                   input radix_type radix,
                                                   input logic [7:0] c);
      logic [4:0]       d;
      acc_type          scaled;
      digit_result_type r;
      d = digit_of(c);
      unique case (radix)
         RADIX_HEX: scaled = acc << 4;
         RADIX_OCT: scaled = acc << 3;
         RADIX_BIN: scaled = acc << 1;
         default:   scaled = (acc << 3) + (acc << 1);
      endcase
      r.acc = acc;
      r.bad = 1'b0;
      if (d >= base_of(radix)) begin
         r.bad = 1'b1;
      end else begin
         r.acc = scaled + acc_type'(d);
      end
      return r;
   endfunction

endpackage

// File: rtl/nlp_step.sv
module nlp_step
   import nlp_pkg::*;
(
   input  parse_state_type state_cur,
   input  logic [7:0]      character,
   output parse_state_type state_next
);

   radix_type        prefix_code;
   digit_result_type held_digit;

   always_comb begin
      prefix_code = RADIX_DEC;
      if (state_cur.count == 2'd1 && state_cur.held == CHAR_0) begin
         case (character) inside
            CHAR_LX, CHAR_UX: prefix_code = RADIX_HEX;
            CHAR_LO, CHAR_UO: prefix_code = RADIX_OCT;
            CHAR_LB, CHAR_UB: prefix_code = RADIX_BIN;
            default:          prefix_code = RADIX_DEC;
         endcase
      end

      held_digit = take_digit(state_cur.acc, state_cur.radix, state_cur.held);

      state_next     = state_cur;
      state_next.dot = state_cur.dot | (character == CHAR_DOT);

      if (state_cur.count == 2'd0) begin
         state_next.held = character;
      end else if (prefix_code != RADIX_DEC) begin
         // The prefix letter is replaced by a zero that adds nothing.
         state_next.radix = prefix_code;
         state_next.held  = CHAR_0;
      end else begin
         state_next.acc  = held_digit.acc;
         state_next.bad  = state_cur.bad | held_digit.bad;
         state_next.held = character;
      end

      if (state_cur.count != 2'd3) begin
         state_next.count = state_cur.count + 2'd1;
      end
   end

endmodule

// File: rtl/nlp_finish.sv
module nlp_finish
   import nlp_pkg::*;
(
   input  pending_type pend,
   output logic [63:0] value,
   output logic        is_unsigned,
   output status_type  status,
   output radix_type   radix_used
);

   digit_result_type last_digit;
   logic             suffix_u;
   logic             suffix_float;
   logic             is_float;
   logic             take_last;
   logic             bad;
   acc_type          acc;

   always_comb begin
      suffix_u     = (pend.final_char == CHAR_LU) || (pend.final_char == CHAR_UU);
      suffix_float = (pend.final_char == CHAR_LF) || (pend.final_char == CHAR_UF) ||
                     (pend.final_char == CHAR_LD) || (pend.final_char == CHAR_UD);
      // In hex, f and d are ordinary digits rather than float suffixes.
      is_float     = pend.dot || (pend.radix != RADIX_HEX && suffix_float);
      take_last    = !suffix_u && !is_float;

      last_digit = take_digit(pend.acc, pend.radix, pend.final_char);
      acc        = take_last ? last_digit.acc : pend.acc;
      bad        = pend.bad | (take_last & last_digit.bad);

      if (is_float) begin
         status = STATUS_FLOAT;
      end else if (bad) begin
         status = STATUS_BAD;
      end else begin
         status = STATUS_OK;
      end

      value       = (status == STATUS_OK) ? 64'(acc) : 64'd0;
      is_unsigned = suffix_u;
      radix_used  = is_float ? RADIX_DEC : pend.radix;
   end

endmodule

// File: rtl/numeric_literal_parser_core.sv
// Numeric literal parser core.
// The request channel carries one character of a C-style integer literal per
// transaction, with req_last marking the final character. A leading 0x, 0o or
// 0b (either case) selects hex, octal or binary; otherwise the literal is
// decimal. A trailing u/U marks it unsigned; a dot, or a trailing f/F/d/D
// outside hex, marks it as a float, which is reported but not evaluated.
// The response channel carries one transaction per literal: the value wrapped
// modulo 2^64, the unsigned flag, a status (ok, float, invalid digit) and the
// radix that was used.
// Throughput is one character per cycle while req_stall is low. After the
// final character is accepted, it passes through the input register, whose
// step logic folds in the held character on its way to the pending stage,
// and then through the pending stage, whose finishing logic folds in the
// final character and forms the status on its way to the response register.
// When the receiver stalls, the response is held steady; the pending stage and
// then the input register fill, after which req_stall rises for a final
// character. Non-final characters keep flowing while a response is stalled.
// A synchronous reset empties every stage and clears the parse state.
module numeric_literal_parser_core
   import nlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_character,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_value,
   output logic        rsp_is_unsigned,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_radix_used
);

   // Input register.
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_char_ff;
   logic            in_last_ff;

   // Parse state carried from character to character.
   parse_state_type state_ff, state_in;
   parse_state_type step_next;

   // Pending stage: a completed literal awaiting its final digit.
   logic            pend_valid_ff, pend_valid_in;
   pending_type     pend_ff;

   // Response register.
   logic            out_valid_ff, out_valid_in;
   logic [63:0]     out_value_ff;
   logic            out_unsigned_ff;
   status_type      out_status_ff;
   radix_type       out_radix_ff;

   logic [63:0]     fin_value;
   logic            fin_unsigned;
   status_type      fin_status;
   radix_type       fin_radix;

   logic            out_ready;
   logic            pend_ready;
   logic            advance;

   nlp_step u_step (
      .state_cur  (state_ff),
      .character  (in_char_ff),
      .state_next (step_next)
   );

   nlp_finish u_finish (
      .pend        (pend_ff),
      .value       (fin_value),
      .is_unsigned (fin_unsigned),
      .status      (fin_status),
      .radix_used  (fin_radix)
   );

   // A non-final character never needs room downstream; a final one needs a
   // free pending slot, which in turn needs the response register to drain.
   always_comb begin
      out_ready  = !out_valid_ff || !rsp_stall;
      pend_ready = !pend_valid_ff || out_ready;
      advance    = in_valid_ff && (!in_last_ff || pend_ready);
      req_stall  = in_valid_ff && !advance;

      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end

      state_in = state_ff;
      if (advance) begin
         // The parse state starts afresh after each literal.
         state_in = in_last_ff ? '0 : step_next;
      end

      pend_valid_in = pend_valid_ff;
      if (pend_ready) begin
         pend_valid_in = advance && in_last_ff;
      end

      out_valid_in = out_valid_ff;
      if (out_ready) begin
         out_valid_in = pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         state_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers load only when their stage takes a transaction.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_character;
         in_last_ff <= req_last;
      end
      if (advance && in_last_ff && pend_ready) begin
         pend_ff.final_char <= step_next.held;
         pend_ff.radix      <= step_next.radix;
         pend_ff.acc        <= step_next.acc;
         pend_ff.bad        <= step_next.bad;
         pend_ff.dot        <= step_next.dot;
      end
      if (pend_valid_ff && out_ready) begin
         out_value_ff    <= fin_value;
         out_unsigned_ff <= fin_unsigned;
         out_status_ff   <= fin_status;
         out_radix_ff    <= fin_radix;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_value       = out_value_ff;
   assign rsp_is_unsigned = out_unsigned_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_radix_used  = out_radix_ff;

endmodule
